### hw/rtl/csm_pkg.sv
// Shared types, constants and helper functions of the centered FIR smoother.
package csm_pkg;

  // Fixed geometry of the filter.
  localparam int MAX_TAPS  = 7;
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int TAP_W     = 3;
  localparam int CNT_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = PROD_W + 3;
  localparam int FRAC_BITS = 14;
  localparam int Q_W       = ACC_W - FRAC_BITS;

  // Output range and the mask that clears the LSB.
  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;
  localparam logic [SAMPLE_W-1:0] LSB_CLEAR = 16'hFFFE;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;

  // Reset values of the configuration registers.
  localparam logic [TAP_W-1:0]         TAP_COUNT_RESET = 3'd1;
  localparam logic signed [COEF_W-1:0] COEF0_RESET     = 16'sd16384;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  // One classified item: a value and how many times to send it.
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [CNT_W-1:0]    count;
    logic                fin;
    logic                short_blk;
  } job_t;

  // A job request from the front end into the queue.
  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  // Effective tap count: zero acts as one, even values round down to odd.
  function automatic logic [TAP_W-1:0] eff_taps(input logic [TAP_W-1:0] tap);
    logic [TAP_W-1:0] t;
    t = tap;
    if (t == '0) begin
      t = TAP_W'(1);
    end else if (!t[0]) begin
      t = t - TAP_W'(1);
    end
    return t;
  endfunction

endpackage

### hw/rtl/centered_fir_smoother.sv
// Top level of the centered FIR smoother.
//
//   channel  | ports                          | contents
//   ---------+--------------------------------+----------------------------------
//   samples  | s_tvalid s_tready s_tdata      | tdata = sample, tlast = block_end
//            | s_tlast                        |
//   results  | m_tvalid m_tready m_tdata      | tdata = smoothed,
//            | m_tlast m_tuser                | tlast = final_res, tuser = short_block
//   config   | cfg_valid cfg_ready cfg_index  | index 0 tap_count, 1..7 coef_0..coef_6
//            | cfg_data                       |
//
// One sample is taken per cycle while each sample yields one result and the
// output is not stalled; a sample that yields n results (start and end of a
// block) holds the output for its n results. The first result of a sample
// passes the product register, the sum register and the job queue into the
// output register.
// The input request waits while the queue plus the two pipeline stages hold
// QUEUE_DEPTH jobs. Reset is synchronous and sets the configuration to its
// defaults; there is no clearing pass.
module centered_fir_smoother #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [csm_pkg::SAMPLE_W-1:0]  s_tdata,    // [15:0] sample
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [csm_pkg::SAMPLE_W-1:0]  m_tdata,    // [15:0] smoothed
  output logic                          m_tlast,
  output logic                          m_tuser,    // [0] short_block
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [csm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csm_pkg::COEF_W-1:0]    cfg_data
);
  import csm_pkg::*;

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  push_t            push;
  logic [OCC_W-1:0] occ;

  csm_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .occ       (occ),
    .push      (push)
  );

  csm_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .occ      (occ),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

### hw/rtl/csm_front.sv
// Front end: configuration, sample window, classification and the MAC pipeline.
module csm_front #(
  parameter int QUEUE_DEPTH = 4,
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [csm_pkg::SAMPLE_W-1:0]         s_tdata,
  input  logic                                 s_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [csm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [csm_pkg::COEF_W-1:0]           cfg_data,
  input  logic [OCC_W-1:0]                     occ,
  output csm_pkg::push_t                       push
);
  import csm_pkg::*;

  logic [TAP_W-1:0] tap_count;
  coef_t            coef [MAX_TAPS];
  sample_t          window [MAX_TAPS];
  logic [CNT_W-1:0] samples_seen;

  sample_t          window_next [MAX_TAPS];
  sample_t          win_sel [MAX_TAPS];
  logic [TAP_W-1:0] taps;
  logic [TAP_W-1:0] half;
  logic [CNT_W-1:0] seen_next;
  logic [CNT_W-1:0] reps;
  job_t             meta;
  logic             accept;
  logic [OCC_W:0]   used;

  logic             s1_valid;
  prod_t            s1_prod [MAX_TAPS];
  job_t             s1_job;
  logic             s2_valid;
  logic signed [ACC_W-1:0] s2_acc;
  job_t             s2_job;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [ACC_W-1:0] biased;
  logic signed [Q_W-1:0]   q;
  logic [SAMPLE_W-1:0]     sat_val;

  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(SAT_MAX);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(SAT_MIN);
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'((1 << FRAC_BITS) - 1);

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RESET;
      for (int k = 0; k < MAX_TAPS; k++) begin
        coef[k] <= (k == 0) ? COEF0_RESET : '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == REG_TAP_COUNT) begin
        tap_count <= cfg_data[TAP_W-1:0];
      end else begin
        coef[cfg_index - CFG_IDX_W'(1)] <= cfg_data;
      end
    end
  end

  // Room is reserved in the queue for every job still in the pipeline.
  assign used = (OCC_W + 1)'(occ) + (OCC_W + 1)'(s1_valid) + (OCC_W + 1)'(s2_valid);
  assign s_tready = used < (OCC_W + 1)'(QUEUE_DEPTH);
  assign accept = s_tvalid && s_tready;

  // Shifted window and the taps that line up with the coefficients.
  always_comb begin
    logic [TAP_W:0] idx;
    idx = '0;
    for (int k = 0; k < MAX_TAPS; k++) begin
      window_next[k] = (k < MAX_TAPS - 1) ? window[(k + 1) % MAX_TAPS] : s_tdata;
    end
    for (int k = 0; k < MAX_TAPS; k++) begin
      idx = (TAP_W + 1)'(MAX_TAPS) - {1'b0, taps} + (TAP_W + 1)'(k);
      win_sel[k] = (TAP_W'(k) < taps) ? window_next[idx[TAP_W-1:0]] : '0;
    end
  end

  // Classify the item: how many results it causes and how they are flagged.
  always_comb begin
    taps      = eff_taps(tap_count);
    half      = taps >> 1;
    seen_next = (samples_seen == CNT_W'(MAX_TAPS)) ? samples_seen
                                                  : samples_seen + CNT_W'(1);
    reps      = (samples_seen < taps) ? half + CNT_W'(1) : CNT_W'(1);
    meta      = '0;
    if (seen_next >= taps) begin
      meta.count = reps + (s_tlast ? half : '0);
      meta.fin   = s_tlast;
    end else if (s_tlast) begin
      meta.count     = seen_next;
      meta.fin       = 1'b1;
      meta.short_blk = 1'b1;
    end
  end

  // Window and block counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
      for (int k = 0; k < MAX_TAPS; k++) begin
        window[k] <= '0;
      end
    end else if (accept) begin
      samples_seen <= s_tlast ? '0 : seen_next;
      for (int k = 0; k < MAX_TAPS; k++) begin
        window[k] <= window_next[k];
      end
    end
  end

  // Pipeline valid bits; items that cause no result leave no job.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (meta.count != '0);
      s2_valid <= s1_valid;
    end
  end

  // Stage one: one product per tap.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      s1_prod[k] <= coef[k] * win_sel[k];
    end
    s1_job <= meta;
  end

  // Stage two: sum of the products.
  always_comb begin
    acc_sum = '0;
    for (int k = 0; k < MAX_TAPS; k++) begin
      acc_sum = acc_sum + ACC_W'(s1_prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    s2_acc <= acc_sum;
    s2_job <= s1_job;
  end

  // Scale toward zero, saturate, clear LSB, zero short blocks, queue the job.
  always_comb begin
    biased = s2_acc + (s2_acc[ACC_W-1] ? ROUND_BIAS : '0);
    q      = biased[ACC_W-1:FRAC_BITS];
    if (q > Q_MAX) begin
      sat_val = SAMPLE_W'(SAT_MAX);
    end else if (q < Q_MIN) begin
      sat_val = SAMPLE_W'(SAT_MIN);
    end else begin
      sat_val = q[SAMPLE_W-1:0];
    end
    push.valid     = s2_valid;
    push.job       = s2_job;
    push.job.value = s2_job.short_blk ? '0 : (sat_val & LSB_CLEAR);
  end

endmodule

### hw/rtl/csm_back.sv
// Back end: job queue and the output register that sends each job's repeats.
module csm_back #(
  parameter int QUEUE_DEPTH = 4,
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1),
  localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  csm_pkg::push_t               push,
  output logic [OCC_W-1:0]             occ,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [csm_pkg::SAMPLE_W-1:0] m_tdata,
  output logic                         m_tlast,
  output logic                         m_tuser
);
  import csm_pkg::*;

  job_t             queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             active;
  job_t             cur;
  logic             load;
  logic             pop;

  // A new job is taken when the output is empty or its last repeat leaves.
  assign load = !active || (m_tready && (cur.count == CNT_W'(1)));
  assign pop  = load && (occ != '0);

  always_ff @(posedge clk) begin
    if (push.valid) begin
      queue[wr_ptr] <= push.job;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
      active <= 1'b0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push.valid, pop})
        2'b10:   occ <= occ + OCC_W'(1);
        2'b01:   occ <= occ - OCC_W'(1);
        default: occ <= occ;
      endcase
      if (load) begin
        active <= (occ != '0);
      end
    end
  end

  // Current job: loaded from the queue, counted down per accepted result.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= queue[rd_ptr];
    end else if (m_tvalid && m_tready) begin
      cur.count <= cur.count - CNT_W'(1);
    end
  end

  assign m_tvalid = active;
  assign m_tdata  = cur.value;
  assign m_tlast  = cur.fin && (cur.count == CNT_W'(1));
  assign m_tuser  = cur.short_blk;

endmodule

### hw/rtl/csm_checker.sv
// Port-level checks of the centered FIR smoother and their binding.
module csm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser,
  input logic        cfg_ready
);

  // A stalled result holds its value and flags.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("result changed while stalled");

  // Smoothed values always have a cleared LSB.
  a_lsb_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[0])
    else $error("smoothed LSB set");

  // Results of a short block are zero.
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 16'h0000)
    else $error("short block result not zero");

  // Nothing is offered right after reset, and both inputs are open.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready && cfg_ready)
    else $error("output valid after reset");

endmodule

bind centered_fir_smoother csm_checker u_csm_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast),
  .m_tuser   (m_tuser),
  .cfg_ready (cfg_ready)
);
